/* src/ea2rm_pkg.sv */
// ----------------------------------------------------------------------------
// ea2rm_pkg
// Shared constants, types and helpers for the Euler angle to matrix block.
// ----------------------------------------------------------------------------
`default_nettype none

package ea2rm_pkg;

   localparam int CORDIC_STAGES     = 16;
   localparam int ELEMENT_FRAC_BITS = 14;
   localparam int ATAN_LEN          = 24;
   localparam int CORDIC_RUN        = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
   localparam int CORDIC_LAT        = CORDIC_RUN + 3;
   localparam int MUL_LAT           = 4;
   localparam int PIPE_LAT          = CORDIC_LAT + MUL_LAT;

   localparam int ANG_W  = 17;
   localparam int TURN_W = 16;
   localparam int RES_W  = 14;
   localparam int CW     = 34;
   localparam int TRIG_W = 32;
   localparam int PROD_W = 64;
   localparam int EL_W   = 16;
   localparam int POS_W  = 32;
   localparam int Q_W    = 2;

   localparam int FULL_TURN    = 46080;
   localparam int EIGHTH_TURN  = 5760;
   localparam int GAIN_Q30     = 652032874;
   localparam int Z_SHIFT      = 17;
   localparam int TRIG_FRAC    = 30;
   localparam int EL_SHIFT     = 2 * TRIG_FRAC - ELEMENT_FRAC_BITS;

   localparam logic [Q_W-1:0] QUAD_0 = 2'd0;
   localparam logic [Q_W-1:0] QUAD_1 = 2'd1;
   localparam logic [Q_W-1:0] QUAD_2 = 2'd2;
   localparam logic [Q_W-1:0] QUAD_3 = 2'd3;

   typedef struct packed {
      logic [EL_W-1:0]  m00;
      logic [EL_W-1:0]  m01;
      logic [EL_W-1:0]  m02;
      logic [EL_W-1:0]  m10;
      logic [EL_W-1:0]  m11;
      logic [EL_W-1:0]  m12;
      logic [EL_W-1:0]  m20;
      logic [EL_W-1:0]  m21;
      logic [EL_W-1:0]  m22;
      logic [POS_W-1:0] t_x;
      logic [POS_W-1:0] t_y;
      logic [POS_W-1:0] t_z;
   } rsp_type;

   function automatic logic [31:0] atan_q24(input int i);
      logic [31:0] v;
      case (i)
         0:       v = 32'd754974720;
         1:       v = 32'd445687602;
         2:       v = 32'd235489089;
         3:       v = 32'd119537938;
         4:       v = 32'd60000934;
         5:       v = 32'd30029717;
         6:       v = 32'd15018523;
         7:       v = 32'd7509720;
         8:       v = 32'd3754917;
         9:       v = 32'd1877466;
         10:      v = 32'd938734;
         11:      v = 32'd469367;
         12:      v = 32'd234684;
         13:      v = 32'd117342;
         14:      v = 32'd58671;
         15:      v = 32'd29335;
         16:      v = 32'd14668;
         17:      v = 32'd7334;
         18:      v = 32'd3667;
         19:      v = 32'd1833;
         20:      v = 32'd917;
         21:      v = 32'd458;
         22:      v = 32'd229;
         23:      v = 32'd115;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [TRIG_W-1:0] rnd30(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] s;
      s = (p + (PROD_W'(1) <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
      return TRIG_W'(s);
   endfunction

   function automatic logic [EL_W-1:0] to_element(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] r;
      logic signed [PROD_W-1:0] lim;
      lim = PROD_W'(1) <<< ELEMENT_FRAC_BITS;
      r   = (v + (PROD_W'(1) <<< (EL_SHIFT - 1))) >>> EL_SHIFT;
      if (r > lim) begin
         r = lim;
      end
      if (r < -lim) begin
         r = -lim;
      end
      return r[EL_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* src/ea2rm_cordic.sv */
// ----------------------------------------------------------------------------
// ea2rm_cordic
// Pipelined sine and cosine of an angle in degrees: turn reduction,
// quadrant split, unrolled rotation-mode CORDIC and quadrant fold.
// ----------------------------------------------------------------------------
`default_nettype none

module ea2rm_cordic (
   input  wire logic                                   clock,
   input  wire logic                                   en,
   input  wire logic signed [ea2rm_pkg::ANG_W-1:0]     ang,
   output logic signed [ea2rm_pkg::TRIG_W-1:0]         sin_val,
   output logic signed [ea2rm_pkg::TRIG_W-1:0]         cos_val
);
   import ea2rm_pkg::*;

   logic signed [ANG_W:0]      ang_x;
   logic [TURN_W-1:0]          turn_in, turn_ff;
   logic [Q_W-1:0]             quad_in;
   logic signed [RES_W-1:0]    res_in;
   logic signed [CW-1:0]       x_ff [0:CORDIC_RUN];
   logic signed [CW-1:0]       y_ff [0:CORDIC_RUN];
   logic signed [CW-1:0]       z_ff [0:CORDIC_RUN];
   logic [Q_W-1:0]             q_ff [0:CORDIC_RUN];
   logic signed [TRIG_W-1:0]   sin_in, sin_ff, cos_in, cos_ff;
   logic [31:0]                tv;

   always_comb begin
      ang_x = {ang[ANG_W-1], ang};
      if (ang_x < 0) begin
         if (ang_x < -(ANG_W+1)'(FULL_TURN)) begin
            turn_in = TURN_W'(32'(ang_x) + 2 * FULL_TURN);
         end else begin
            turn_in = TURN_W'(32'(ang_x) + FULL_TURN);
         end
      end else if (ang_x >= (ANG_W+1)'(FULL_TURN)) begin
         turn_in = TURN_W'(32'(ang_x) - FULL_TURN);
      end else begin
         turn_in = TURN_W'(ang_x);
      end
   end

   always_comb begin
      tv = 32'(turn_ff);
      if (tv < EIGHTH_TURN) begin
         quad_in = QUAD_0;
         res_in  = RES_W'(tv);
      end else if (tv < 3 * EIGHTH_TURN) begin
         quad_in = QUAD_1;
         res_in  = RES_W'(tv - 2 * EIGHTH_TURN);
      end else if (tv < 5 * EIGHTH_TURN) begin
         quad_in = QUAD_2;
         res_in  = RES_W'(tv - 4 * EIGHTH_TURN);
      end else if (tv < 7 * EIGHTH_TURN) begin
         quad_in = QUAD_3;
         res_in  = RES_W'(tv - 6 * EIGHTH_TURN);
      end else begin
         quad_in = QUAD_0;
         res_in  = RES_W'(tv - 8 * EIGHTH_TURN);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         turn_ff <= turn_in;
         x_ff[0] <= CW'(GAIN_Q30);
         y_ff[0] <= '0;
         z_ff[0] <= CW'(res_in) <<< Z_SHIFT;
         q_ff[0] <= quad_in;
      end
   end

   for (genvar i = 0; i < CORDIC_RUN; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[i+1] <= q_ff[i];
            if (!z_ff[i][CW-1]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - CW'(atan_q24(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + CW'(atan_q24(i));
            end
         end
      end
   end

   always_comb begin
      case (q_ff[CORDIC_RUN])
         QUAD_0: begin
            cos_in = TRIG_W'(x_ff[CORDIC_RUN]);
            sin_in = TRIG_W'(y_ff[CORDIC_RUN]);
         end
         QUAD_1: begin
            cos_in = TRIG_W'(-y_ff[CORDIC_RUN]);
            sin_in = TRIG_W'(x_ff[CORDIC_RUN]);
         end
         QUAD_2: begin
            cos_in = TRIG_W'(-x_ff[CORDIC_RUN]);
            sin_in = TRIG_W'(-y_ff[CORDIC_RUN]);
         end
         default: begin
            cos_in = TRIG_W'(y_ff[CORDIC_RUN]);
            sin_in = TRIG_W'(-x_ff[CORDIC_RUN]);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule

`default_nettype wire

/* src/euler_angles_to_rotation_matrix_top.sv */
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix_top
// ZYX Euler angles plus position to a 3x4 affine matrix, Q2.14 rotation.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one pose beat: pitch, yaw, roll (degrees, 7 fraction bits)
//   and a 32-bit position. rsp_* carries one matrix beat: nine rotation
//   elements and the position copied into column three. Both channels use
//   valid/ready; a beat moves when both are high.
//   Throughput: one beat per cycle while the skid register is empty. Beats
//   pass through CORDIC_STAGES + 8 register stages on their way to response
//   valid (reduction and quadrant split 2, CORDIC stages, quadrant fold 1,
//   four multiply and round stages, output register 1), a count set by the
//   unrolled CORDIC depth.
//   The pipeline advances in lockstep. When the receiver stalls, one more
//   beat lands in a skid register behind the output register; after that
//   req_ready drops until the skid drains. Nothing is lost or repeated.
//   Reset clears all valid bits; the block accepts a beat in the first
//   cycle after reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_angles_to_rotation_matrix_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [ea2rm_pkg::ANG_W-1:0]    req_pitch_angle,
   input  wire logic signed [ea2rm_pkg::ANG_W-1:0]    req_yaw_angle,
   input  wire logic signed [ea2rm_pkg::ANG_W-1:0]    req_roll_angle,
   input  wire logic signed [ea2rm_pkg::POS_W-1:0]    req_pos_x,
   input  wire logic signed [ea2rm_pkg::POS_W-1:0]    req_pos_y,
   input  wire logic signed [ea2rm_pkg::POS_W-1:0]    req_pos_z,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [ea2rm_pkg::EL_W-1:0]          rsp_m00,
   output logic signed [ea2rm_pkg::EL_W-1:0]          rsp_m01,
   output logic signed [ea2rm_pkg::EL_W-1:0]          rsp_m02,
   output logic signed [ea2rm_pkg::EL_W-1:0]          rsp_m10,
   output logic signed [ea2rm_pkg::EL_W-1:0]          rsp_m11,
   output logic signed [ea2rm_pkg::EL_W-1:0]          rsp_m12,
   output logic signed [ea2rm_pkg::EL_W-1:0]          rsp_m20,
   output logic signed [ea2rm_pkg::EL_W-1:0]          rsp_m21,
   output logic signed [ea2rm_pkg::EL_W-1:0]          rsp_m22,
   output logic signed [ea2rm_pkg::POS_W-1:0]         rsp_t_x,
   output logic signed [ea2rm_pkg::POS_W-1:0]         rsp_t_y,
   output logic signed [ea2rm_pkg::POS_W-1:0]         rsp_t_z
);
   import ea2rm_pkg::*;

   logic                        en;
   logic [PIPE_LAT-1:0]         vld_ff;
   logic [POS_W-1:0]            px_ff [0:PIPE_LAT-2];
   logic [POS_W-1:0]            py_ff [0:PIPE_LAT-2];
   logic [POS_W-1:0]            pz_ff [0:PIPE_LAT-2];

   logic signed [TRIG_W-1:0]    sp, cp, sy, cy, sr, cr;

   logic signed [PROD_W-1:0]    crcy1_ff, crsy1_ff, srcy1_ff, srsy1_ff;
   logic signed [PROD_W-1:0]    cpcy1_ff, cpsy1_ff, srcp1_ff, crcp1_ff;
   logic signed [TRIG_W-1:0]    sp1_ff;

   logic signed [TRIG_W-1:0]    crcy2_ff, crsy2_ff, srcy2_ff, srsy2_ff, sp2_ff;
   logic [EL_W-1:0]             e00_2_ff, e10_2_ff, e20_2_ff, e21_2_ff, e22_2_ff;

   logic signed [PROD_W-1:0]    t01_ff, t02_ff, t11_ff, t12_ff;
   logic signed [TRIG_W-1:0]    crcy3_ff, crsy3_ff, srcy3_ff, srsy3_ff;
   logic [EL_W-1:0]             e00_3_ff, e10_3_ff, e20_3_ff, e21_3_ff, e22_3_ff;

   rsp_type                     pipe_ff;
   rsp_type                     out_ff, skid_ff;
   logic                        out_v_ff, skid_v_ff;

   assign en        = !skid_v_ff;
   assign req_ready = en;

   ea2rm_cordic u_pitch (.clock(clock), .en(en), .ang(req_pitch_angle),
                         .sin_val(sp), .cos_val(cp));
   ea2rm_cordic u_yaw   (.clock(clock), .en(en), .ang(req_yaw_angle),
                         .sin_val(sy), .cos_val(cy));
   ea2rm_cordic u_roll  (.clock(clock), .en(en), .ang(req_roll_angle),
                         .sin_val(sr), .cos_val(cr));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff[0] <= req_pos_x;
         py_ff[0] <= req_pos_y;
         pz_ff[0] <= req_pos_z;
      end
   end

   for (genvar i = 1; i < PIPE_LAT - 1; i++) begin : g_pos
      always_ff @(posedge clock) begin
         if (en) begin
            px_ff[i] <= px_ff[i-1];
            py_ff[i] <= py_ff[i-1];
            pz_ff[i] <= pz_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         crcy1_ff <= PROD_W'(cr) * PROD_W'(cy);
         crsy1_ff <= PROD_W'(cr) * PROD_W'(sy);
         srcy1_ff <= PROD_W'(sr) * PROD_W'(cy);
         srsy1_ff <= PROD_W'(sr) * PROD_W'(sy);
         cpcy1_ff <= PROD_W'(cp) * PROD_W'(cy);
         cpsy1_ff <= PROD_W'(cp) * PROD_W'(sy);
         srcp1_ff <= PROD_W'(sr) * PROD_W'(cp);
         crcp1_ff <= PROD_W'(cr) * PROD_W'(cp);
         sp1_ff   <= sp;

         crcy2_ff <= rnd30(crcy1_ff);
         crsy2_ff <= rnd30(crsy1_ff);
         srcy2_ff <= rnd30(srcy1_ff);
         srsy2_ff <= rnd30(srsy1_ff);
         sp2_ff   <= sp1_ff;
         e00_2_ff <= to_element(cpcy1_ff);
         e10_2_ff <= to_element(cpsy1_ff);
         e20_2_ff <= to_element(-(PROD_W'(sp1_ff) <<< TRIG_FRAC));
         e21_2_ff <= to_element(srcp1_ff);
         e22_2_ff <= to_element(crcp1_ff);

         t01_ff   <= PROD_W'(sp2_ff) * PROD_W'(srcy2_ff);
         t02_ff   <= PROD_W'(sp2_ff) * PROD_W'(crcy2_ff);
         t11_ff   <= PROD_W'(sp2_ff) * PROD_W'(srsy2_ff);
         t12_ff   <= PROD_W'(sp2_ff) * PROD_W'(crsy2_ff);
         crcy3_ff <= crcy2_ff;
         crsy3_ff <= crsy2_ff;
         srcy3_ff <= srcy2_ff;
         srsy3_ff <= srsy2_ff;
         e00_3_ff <= e00_2_ff;
         e10_3_ff <= e10_2_ff;
         e20_3_ff <= e20_2_ff;
         e21_3_ff <= e21_2_ff;
         e22_3_ff <= e22_2_ff;

         pipe_ff.m00 <= e00_3_ff;
         pipe_ff.m01 <= to_element(t01_ff - (PROD_W'(crsy3_ff) <<< TRIG_FRAC));
         pipe_ff.m02 <= to_element(t02_ff + (PROD_W'(srsy3_ff) <<< TRIG_FRAC));
         pipe_ff.m10 <= e10_3_ff;
         pipe_ff.m11 <= to_element(t11_ff + (PROD_W'(crcy3_ff) <<< TRIG_FRAC));
         pipe_ff.m12 <= to_element(t12_ff - (PROD_W'(srcy3_ff) <<< TRIG_FRAC));
         pipe_ff.m20 <= e20_3_ff;
         pipe_ff.m21 <= e21_3_ff;
         pipe_ff.m22 <= e22_3_ff;
         pipe_ff.t_x <= px_ff[PIPE_LAT-2];
         pipe_ff.t_y <= py_ff[PIPE_LAT-2];
         pipe_ff.t_z <= pz_ff[PIPE_LAT-2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (rsp_ready || !out_v_ff) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff  <= vld_ff[PIPE_LAT-1];
         end
      end else if (vld_ff[PIPE_LAT-1] && en) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ready || !out_v_ff) begin
         out_ff <= skid_v_ff ? skid_ff : pipe_ff;
      end else if (en) begin
         skid_ff <= pipe_ff;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_m00   = out_ff.m00;
   assign rsp_m01   = out_ff.m01;
   assign rsp_m02   = out_ff.m02;
   assign rsp_m10   = out_ff.m10;
   assign rsp_m11   = out_ff.m11;
   assign rsp_m12   = out_ff.m12;
   assign rsp_m20   = out_ff.m20;
   assign rsp_m21   = out_ff.m21;
   assign rsp_m22   = out_ff.m22;
   assign rsp_t_x   = out_ff.t_x;
   assign rsp_t_y   = out_ff.t_y;
   assign rsp_t_z   = out_ff.t_z;

endmodule

`default_nettype wire

/* tb/euler_angles_to_rotation_matrix_checker.sv */
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix_checker
// Watches the pose and matrix channels, computes the expected matrix for
// every accepted pose beat and compares each matrix beat field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_angles_to_rotation_matrix_checker (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire logic signed [16:0]   req_pitch_angle,
   input  wire logic signed [16:0]   req_yaw_angle,
   input  wire logic signed [16:0]   req_roll_angle,
   input  wire logic signed [31:0]   req_pos_x,
   input  wire logic signed [31:0]   req_pos_y,
   input  wire logic signed [31:0]   req_pos_z,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire logic signed [15:0]   rsp_m00,
   input  wire logic signed [15:0]   rsp_m01,
   input  wire logic signed [15:0]   rsp_m02,
   input  wire logic signed [15:0]   rsp_m10,
   input  wire logic signed [15:0]   rsp_m11,
   input  wire logic signed [15:0]   rsp_m12,
   input  wire logic signed [15:0]   rsp_m20,
   input  wire logic signed [15:0]   rsp_m21,
   input  wire logic signed [15:0]   rsp_m22,
   input  wire logic signed [31:0]   rsp_t_x,
   input  wire logic signed [31:0]   rsp_t_y,
   input  wire logic signed [31:0]   rsp_t_z,
   output int                        fail_count,
   output int                        pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import ea2rm_pkg::*;

   localparam longint TURN    = 46080;
   localparam longint QUARTER = 11520;
   localparam longint EIGHTH  = 5760;
   localparam longint GAIN    = 652032874;

   longint atan_deg[24] = '{
      754974720, 445687602, 235489089, 119537938, 60000934, 30029717,
      15018523, 7509720, 3754917, 1877466, 938734, 469367,
      234684, 117342, 58671, 29335, 14668, 7334,
      3667, 1833, 917, 458, 229, 115};

   rsp_type matrix_queue[$];

   function automatic void trig_of(input longint ang, output longint sn,
                                   output longint cs);
      longint a, r, x, y, z, t;
      int q;
      a = ang % TURN;
      if (a < 0) a += TURN;
      q = int'(a / QUARTER);
      r = a - q * QUARTER;
      if (r >= EIGHTH) begin
         r -= QUARTER;
         q = (q + 1) & 3;
      end
      x = GAIN;
      y = 0;
      z = r * 131072;
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z -= atan_deg[i];
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z += atan_deg[i];
         end
         x = t;
      end
      case (q)
         0: begin cs = x;  sn = y;  end
         1: begin cs = -y; sn = x;  end
         2: begin cs = -x; sn = -y; end
         default: begin cs = y; sn = -x; end
      endcase
   endfunction

   function automatic longint prod_q30(input longint a, input longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic logic [15:0] round_element(input longint v);
      longint r, lim;
      int s;
      s = 60 - ELEMENT_FRAC_BITS;
      lim = 64'sd1 <<< ELEMENT_FRAC_BITS;
      r = (v + (64'sd1 <<< (s - 1))) >>> s;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[15:0];
   endfunction

   function automatic rsp_type pose_matrix(input longint p, input longint yw,
                                           input longint rl, input logic [31:0] x,
                                           input logic [31:0] y, input logic [31:0] z);
      longint sp, cp, sy, cy, sr, cr, crcy, crsy, srcy, srsy, one;
      rsp_type m;
      one = 64'sd1 <<< 30;
      trig_of(p, sp, cp);
      trig_of(yw, sy, cy);
      trig_of(rl, sr, cr);
      crcy = prod_q30(cr, cy);
      crsy = prod_q30(cr, sy);
      srcy = prod_q30(sr, cy);
      srsy = prod_q30(sr, sy);
      m.m00 = round_element(cp * cy);
      m.m01 = round_element(sp * srcy - crsy * one);
      m.m02 = round_element(sp * crcy + srsy * one);
      m.m10 = round_element(cp * sy);
      m.m11 = round_element(sp * srsy + crcy * one);
      m.m12 = round_element(sp * crsy - srcy * one);
      m.m20 = round_element(-sp * one);
      m.m21 = round_element(sr * cp);
      m.m22 = round_element(cr * cp);
      m.t_x = x;
      m.t_y = y;
      m.t_z = z;
      return m;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d actual %0d", name, $signed(exp_v),
                $signed(act_v));
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (req_valid && req_ready) begin
            matrix_queue.push_back(pose_matrix(req_pitch_angle, req_yaw_angle,
               req_roll_angle, req_pos_x, req_pos_y, req_pos_z));
         end
         if (rsp_valid && rsp_ready) begin
            if (matrix_queue.size() == 0) begin
               $error("matrix beat with no pose pending");
               fail_count++;
            end else begin
               e = matrix_queue.pop_front();
               compare_field("m00", 32'(signed'(e.m00)), 32'(rsp_m00));
               compare_field("m01", 32'(signed'(e.m01)), 32'(rsp_m01));
               compare_field("m02", 32'(signed'(e.m02)), 32'(rsp_m02));
               compare_field("m10", 32'(signed'(e.m10)), 32'(rsp_m10));
               compare_field("m11", 32'(signed'(e.m11)), 32'(rsp_m11));
               compare_field("m12", 32'(signed'(e.m12)), 32'(rsp_m12));
               compare_field("m20", 32'(signed'(e.m20)), 32'(rsp_m20));
               compare_field("m21", 32'(signed'(e.m21)), 32'(rsp_m21));
               compare_field("m22", 32'(signed'(e.m22)), 32'(rsp_m22));
               compare_field("t_x", e.t_x, rsp_t_x);
               compare_field("t_y", e.t_y, rsp_t_y);
               compare_field("t_z", e.t_z, rsp_t_z);
            end
         end
         pending_count <= matrix_queue.size();
      end
   end

endmodule

`default_nettype wire

/* tb/euler_angles_to_rotation_matrix_top_tb.sv */
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix_top_tb
// Drives pose beats with random gaps and receiver stalls into the matrix
// block, including angle extremes and wrap cases, and reports the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_angles_to_rotation_matrix_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ea2rm_pkg::*;

   localparam int RANDOM_POSES = 1900;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [16:0] req_pitch_angle = '0;
   logic signed [16:0] req_yaw_angle = '0;
   logic signed [16:0] req_roll_angle = '0;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [31:0] req_pos_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12;
   logic signed [15:0] rsp_m20, rsp_m21, rsp_m22;
   logic signed [31:0] rsp_t_x, rsp_t_y, rsp_t_z;
   int fail_count;
   int pending_count;
   bit long_stall = 1'b0;

   always #5 clock = ~clock;

   euler_angles_to_rotation_matrix_top i_dut (.*);
   euler_angles_to_rotation_matrix_checker i_checker (.*);

   function automatic int gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   function automatic logic signed [16:0] pick_angle();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return 17'(-46080);
      if (k == 1) return 17'(46080);
      if (k == 2) return 17'(5760 * (int'($urandom_range(0, 16)) - 8)
                             + int'($urandom_range(0, 2)) - 1);
      if (k == 3) return 17'($urandom_range(0, 131071));
      return 17'($urandom_range(0, 92160) - 46080);
   endfunction

   task automatic send_pose(input int p, input int yw, input int rl,
                            input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
      req_valid <= 1'b1;
      req_pitch_angle <= 17'(p);
      req_yaw_angle <= 17'(yw);
      req_roll_angle <= 17'(rl);
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic idle_for(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (long_stall) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 4) != 0) || ($urandom_range(0, 99) < 2 ? 1'b0 : 1'b1)
         ? ($urandom_range(0, 29) != 0) : 1'b0;
   end

   initial begin
      int dir_angles[10] = '{0, 46080, -46080, 5760, -5760, 5759, 11520, -11520, 23040, 34560};
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_angles[i]) begin
         send_pose(dir_angles[i], dir_angles[(i + 3) % 10], dir_angles[(i + 7) % 10],
                   32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      end
      send_pose(0, 0, 0, 0, 0, 0);
      send_pose(17'h0FFFF, 17'h10000, 17'h1FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'd1);
      send_pose(17'h10000, 17'h0FFFF, 17'h00001, 32'h5555_5555, 32'hAAAA_AAAA, 32'd0);
      send_pose(11519, 11521, 17'(-1), 32'd7, 32'd8, 32'd9);
      long_stall = 1'b1;
      fork
         begin
            repeat (60) @(posedge clock);
            long_stall = 1'b0;
         end
      join_none
      for (int i = 0; i < 2 * PIPE_LAT + 10; i++) begin
         send_pose(pick_angle(), pick_angle(), pick_angle(),
                   $urandom(), $urandom(), $urandom());
      end
      for (int i = 0; i < RANDOM_POSES; i++) begin
         if (i == RANDOM_POSES / 2) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_count != 0);
         end
         send_pose(pick_angle(), pick_angle(), pick_angle(),
                   $urandom(), $urandom(), $urandom());
         if (i % 300 < 250) idle_for(gap_len());
      end
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (PIPE_LAT + 10) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire

/* euler_angles_to_rotation_matrix_top.f */
src/ea2rm_pkg.sv
src/ea2rm_cordic.sv
src/euler_angles_to_rotation_matrix_top.sv
tb/euler_angles_to_rotation_matrix_checker.sv
tb/euler_angles_to_rotation_matrix_top_tb.sv
